// ===== rtl/dltq_pkg.sv =====
// ----------------------------------------------------------------------------
// dltq_pkg: shared definitions for the delta list timer queue
// Operation and status codes, controller types, command set and saturation.
// ----------------------------------------------------------------------------
package dltq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int DW          = 18;   // stored relative delay width
    localparam int TW          = 28;   // working width of the running delay

    localparam logic [1:0] OP_ADD  = 2'd0;
    localparam logic [1:0] OP_DEL  = 2'd1;
    localparam logic [1:0] OP_TICK = 2'd2;
    localparam logic [1:0] OP_ADV  = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;

    typedef enum logic [2:0] {S_IDLE, S_START, S_RD, S_EV, S_OUT} t_state;

    typedef enum logic [2:0] {M_ADD_SRCH, M_SHIFT, M_DEL, M_RM, M_TICK, M_ADV} t_mode;

    typedef enum logic [4:0] {
        C_NONE, C_LOAD, C_READ, C_ADD_TAIL, C_ADD_SKIP, C_ADD_STEP, C_ADD_INS,
        C_SHIFT, C_SHIFT_END, C_DEL_NEXT, C_NOTFOUND, C_FULL, C_RM_START,
        C_RM_STEP, C_RM_END, C_TICK_WR, C_TICK_EXP, C_ADV_HIT
    } t_cmd;

    typedef struct packed {
        logic [1:0] op;
        logic       cnt_zero;
        logic       full;
        logic       idx_is_cnt;
        logic       next_is_cnt;
        logic       idx_zero;
        logic       lt;
        logic       seq_hit;
        logic       base_hit;
        logic       tick_exp;
    } t_dp_stat;

    // Clamp a working value to the signed 18-bit delay range.
    function automatic logic signed [DW-1:0] sat18(input logic signed [TW-1:0] v);
        logic signed [TW-1:0] hi;
        logic signed [TW-1:0] lo;
        hi = TW'(signed'({1'b0, {(DW-1){1'b1}}}));
        lo = -hi - TW'(1);
        if (v > hi) begin
            sat18 = DW'(hi);
        end else if (v < lo) begin
            sat18 = DW'(lo);
        end else begin
            sat18 = DW'(v);
        end
    endfunction

endpackage

// ===== rtl/dltq_ctrl.sv =====
// ----------------------------------------------------------------------------
// dltq_ctrl: sequencing controller
// Walks the stored entries one read and one evaluation at a time.
// ----------------------------------------------------------------------------
module dltq_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               i_stall,
    input  dltq_pkg::t_dp_stat i_stat,
    output dltq_pkg::t_cmd     o_cmd,
    output logic               o_valid,
    output logic               o_stall
);

    dltq_pkg::t_state r_state, n_state;
    dltq_pkg::t_mode  r_mode, n_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dltq_pkg::S_IDLE;
            r_mode  <= dltq_pkg::M_ADD_SRCH;
        end else begin
            r_state <= n_state;
            r_mode  <= n_mode;
        end
    end

    always_comb begin
        n_state = r_state;
        n_mode  = r_mode;
        o_cmd   = dltq_pkg::C_NONE;
        o_valid = 1'b0;
        o_stall = (r_state != dltq_pkg::S_IDLE);
        unique case (r_state)
            dltq_pkg::S_IDLE: begin
                if (i_valid) begin
                    o_cmd   = dltq_pkg::C_LOAD;
                    n_state = dltq_pkg::S_START;
                end
            end
            dltq_pkg::S_START: begin
                n_state = dltq_pkg::S_RD;
                unique case (i_stat.op)
                    dltq_pkg::OP_ADD: begin
                        n_mode = dltq_pkg::M_ADD_SRCH;
                        if (i_stat.full) begin
                            o_cmd   = dltq_pkg::C_FULL;
                            n_state = dltq_pkg::S_OUT;
                        end
                    end
                    dltq_pkg::OP_DEL: begin
                        n_mode = dltq_pkg::M_DEL;
                        if (i_stat.cnt_zero) begin
                            o_cmd   = dltq_pkg::C_NOTFOUND;
                            n_state = dltq_pkg::S_OUT;
                        end
                    end
                    dltq_pkg::OP_TICK: begin
                        n_mode = dltq_pkg::M_TICK;
                        if (i_stat.cnt_zero) n_state = dltq_pkg::S_OUT;
                    end
                    default: begin
                        n_mode = dltq_pkg::M_ADV;
                        if (i_stat.cnt_zero) n_state = dltq_pkg::S_OUT;
                    end
                endcase
            end
            dltq_pkg::S_RD: begin
                if (i_stat.idx_is_cnt) begin
                    n_state = dltq_pkg::S_OUT;
                    case (r_mode)
                        dltq_pkg::M_ADD_SRCH: o_cmd = dltq_pkg::C_ADD_TAIL;
                        dltq_pkg::M_SHIFT:    o_cmd = dltq_pkg::C_SHIFT_END;
                        dltq_pkg::M_RM: begin
                            o_cmd = dltq_pkg::C_RM_END;
                            if (i_stat.op == dltq_pkg::OP_ADV) n_state = dltq_pkg::S_START;
                        end
                        default: o_cmd = dltq_pkg::C_NONE;
                    endcase
                end else begin
                    o_cmd   = dltq_pkg::C_READ;
                    n_state = dltq_pkg::S_EV;
                end
            end
            dltq_pkg::S_EV: begin
                n_state = dltq_pkg::S_RD;
                case (r_mode)
                    dltq_pkg::M_ADD_SRCH: begin
                        if (i_stat.lt) begin
                            o_cmd  = dltq_pkg::C_ADD_INS;
                            n_mode = dltq_pkg::M_SHIFT;
                        end else if (i_stat.idx_zero) begin
                            o_cmd = dltq_pkg::C_ADD_SKIP;
                        end else begin
                            o_cmd = dltq_pkg::C_ADD_STEP;
                        end
                    end
                    dltq_pkg::M_SHIFT: o_cmd = dltq_pkg::C_SHIFT;
                    dltq_pkg::M_DEL: begin
                        if (i_stat.seq_hit) begin
                            o_cmd  = dltq_pkg::C_RM_START;
                            n_mode = dltq_pkg::M_RM;
                        end else if (i_stat.next_is_cnt) begin
                            o_cmd   = dltq_pkg::C_NOTFOUND;
                            n_state = dltq_pkg::S_OUT;
                        end else begin
                            o_cmd = dltq_pkg::C_DEL_NEXT;
                        end
                    end
                    dltq_pkg::M_RM: o_cmd = dltq_pkg::C_RM_STEP;
                    dltq_pkg::M_TICK: begin
                        if (i_stat.tick_exp) begin
                            o_cmd  = dltq_pkg::C_TICK_EXP;
                            n_mode = dltq_pkg::M_RM;
                        end else begin
                            o_cmd   = dltq_pkg::C_TICK_WR;
                            n_state = dltq_pkg::S_OUT;
                        end
                    end
                    default: begin
                        if (i_stat.base_hit) begin
                            o_cmd  = dltq_pkg::C_ADV_HIT;
                            n_mode = dltq_pkg::M_RM;
                        end else begin
                            n_state = dltq_pkg::S_OUT;
                        end
                    end
                endcase
            end
            default: begin
                o_valid = 1'b1;
                if (!i_stall) n_state = dltq_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/dltq_dp.sv =====
// ----------------------------------------------------------------------------
// dltq_dp: queue datapath
// Entry memories, count, running delay, carry and fold registers, results.
// ----------------------------------------------------------------------------
module dltq_dp #(
    parameter int DEPTH = dltq_pkg::QUEUE_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  dltq_pkg::t_cmd     i_cmd,
    input  logic [1:0]         i_op,
    input  logic [15:0]        i_seq_id,
    input  logic [15:0]        i_delay_ticks,
    input  logic [15:0]        i_window_base,
    output dltq_pkg::t_dp_stat o_stat,
    output logic               o_expired,
    output logic [15:0]        o_expired_seq,
    output logic [15:0]        o_new_base,
    output logic [1:0]         o_status,
    output logic [4:0]         o_entries
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = $clog2(DEPTH);
    localparam int DW = dltq_pkg::DW;
    localparam int TW = dltq_pkg::TW;

    logic [15:0]          m_seq   [DEPTH];
    logic signed [DW-1:0] m_delta [DEPTH];

    logic [CW-1:0]        r_idx, r_cnt;
    logic [1:0]           r_op;
    logic [15:0]          r_seq, r_base, r_cs, r_rd_seq, r_exp_seq;
    logic signed [TW-1:0] r_t;
    logic signed [DW-1:0] r_cd, r_f, r_rd_delta;
    logic                 r_first, r_expired;
    logic [1:0]           r_status;

    logic signed [TW-1:0] ext_d;
    logic signed [DW-1:0] nd;
    logic                 we;
    logic [IW-1:0]        wa;
    logic [15:0]          ws;
    logic signed [DW-1:0] wd;

    assign ext_d = TW'(r_rd_delta);
    assign nd    = dltq_pkg::sat18(ext_d - TW'(1));

    always_comb begin
        we = 1'b0;
        wa = r_idx[IW-1:0];
        ws = r_seq;
        wd = dltq_pkg::sat18(r_t);
        case (i_cmd) inside
            dltq_pkg::C_ADD_TAIL, dltq_pkg::C_ADD_INS: we = 1'b1;
            dltq_pkg::C_SHIFT, dltq_pkg::C_SHIFT_END: begin
                we = 1'b1;
                ws = r_cs;
                wd = r_cd;
            end
            dltq_pkg::C_RM_STEP: begin
                we = 1'b1;
                wa = IW'(r_idx - CW'(1));
                ws = r_rd_seq;
                wd = r_first ? dltq_pkg::sat18(ext_d + TW'(r_f)) : r_rd_delta;
            end
            dltq_pkg::C_TICK_WR: begin
                we = 1'b1;
                ws = r_rd_seq;
                wd = nd;
            end
            default: we = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            m_seq[wa]   <= ws;
            m_delta[wa] <= wd;
        end
        if (i_cmd == dltq_pkg::C_READ) begin
            r_rd_seq   <= m_seq[r_idx[IW-1:0]];
            r_rd_delta <= m_delta[r_idx[IW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_idx <= '0;
            r_op  <= dltq_pkg::OP_ADD;
        end else begin
            case (i_cmd) inside
                dltq_pkg::C_LOAD: begin
                    r_op      <= i_op;
                    r_seq     <= i_seq_id;
                    r_base    <= i_window_base;
                    r_t       <= TW'(i_delay_ticks);
                    r_idx     <= '0;
                    r_expired <= 1'b0;
                    r_exp_seq <= '0;
                    r_status  <= dltq_pkg::ST_OK;
                end
                dltq_pkg::C_ADD_TAIL, dltq_pkg::C_SHIFT_END: r_cnt <= r_cnt + CW'(1);
                dltq_pkg::C_ADD_SKIP, dltq_pkg::C_DEL_NEXT: r_idx <= r_idx + CW'(1);
                dltq_pkg::C_ADD_STEP: begin
                    r_t   <= r_t - ext_d;
                    r_idx <= r_idx + CW'(1);
                end
                dltq_pkg::C_ADD_INS: begin
                    r_cs  <= r_rd_seq;
                    r_cd  <= dltq_pkg::sat18(ext_d - r_t);
                    r_idx <= r_idx + CW'(1);
                end
                dltq_pkg::C_SHIFT: begin
                    r_cs  <= r_rd_seq;
                    r_cd  <= r_rd_delta;
                    r_idx <= r_idx + CW'(1);
                end
                dltq_pkg::C_NOTFOUND: r_status <= dltq_pkg::ST_NOT_FOUND;
                dltq_pkg::C_FULL:     r_status <= dltq_pkg::ST_FULL;
                dltq_pkg::C_RM_START: begin
                    r_f     <= r_rd_delta;
                    r_first <= 1'b1;
                    r_idx   <= r_idx + CW'(1);
                end
                dltq_pkg::C_RM_STEP: begin
                    r_first <= 1'b0;
                    r_idx   <= r_idx + CW'(1);
                end
                dltq_pkg::C_RM_END: begin
                    r_cnt <= r_cnt - CW'(1);
                    r_idx <= '0;
                end
                dltq_pkg::C_TICK_EXP: begin
                    r_expired <= 1'b1;
                    r_exp_seq <= r_rd_seq;
                    r_f       <= nd;
                    r_first   <= 1'b1;
                    r_idx     <= r_idx + CW'(1);
                end
                dltq_pkg::C_ADV_HIT: begin
                    r_f     <= r_rd_delta;
                    r_first <= 1'b1;
                    r_base  <= r_base + 16'd1;
                    r_idx   <= r_idx + CW'(1);
                end
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_comb begin
        o_stat.op          = r_op;
        o_stat.cnt_zero    = (r_cnt == '0);
        o_stat.full        = (r_cnt == CW'(DEPTH));
        o_stat.idx_is_cnt  = (r_idx == r_cnt);
        o_stat.next_is_cnt = (({1'b0, r_idx} + (CW + 1)'(1)) == {1'b0, r_cnt});
        o_stat.idx_zero    = (r_idx == '0);
        o_stat.lt          = (r_t < ext_d);
        o_stat.seq_hit     = (r_rd_seq == r_seq);
        o_stat.base_hit    = (r_rd_seq == r_base);
        o_stat.tick_exp    = (nd <= 0);
    end

    assign o_expired     = r_expired;
    assign o_expired_seq = r_exp_seq;
    assign o_new_base    = (r_op == dltq_pkg::OP_ADV) ? r_base : 16'd0;
    assign o_status      = r_status;
    assign o_entries     = 5'(r_cnt);

endmodule

// ===== rtl/delta_list_timer_queue.sv =====
// ----------------------------------------------------------------------------
// delta_list_timer_queue: retransmission timers kept as a delta list
// Add, delete, tick and window advance over a fixed-depth ordered queue.
// ----------------------------------------------------------------------------
// Each request walks the entries held: an add searches for its place and
// shifts the later entries up (it is dropped when the queue is full); a delete
// searches for the sequence number and shifts the later entries down; a tick
// updates the head and removes it on expiry; an advance removes each matching
// head in turn. One request at a time: a new one is taken after the result is.
// Reset: the entry count clears to zero; the entry memories are not cleared.
module delta_list_timer_queue #(
    parameter int QUEUE_DEPTH = dltq_pkg::QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_op,
    input  logic [15:0] i_seq_id,
    input  logic [15:0] i_delay_ticks,
    input  logic [15:0] i_window_base,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_expired,
    output logic [15:0] o_expired_seq,
    output logic [15:0] o_new_base,
    output logic [1:0]  o_status,
    output logic [4:0]  o_entries
);

    // The controller steps through the walk; the datapath holds the entries
    // and works out every comparison the controller needs. Each step of a walk
    // is one read of the entry memory and one evaluation.
    dltq_pkg::t_cmd     cmd;
    dltq_pkg::t_dp_stat stat;

    dltq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_stall (i_stall),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_valid (o_valid),
        .o_stall (o_stall)
    );

    // The payload of a request is captured when it is taken, so the result
    // registers stay steady while the result waits downstream.
    dltq_dp #(.DEPTH(QUEUE_DEPTH)) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_op          (i_op),
        .i_seq_id      (i_seq_id),
        .i_delay_ticks (i_delay_ticks),
        .i_window_base (i_window_base),
        .o_stat        (stat),
        .o_expired     (o_expired),
        .o_expired_seq (o_expired_seq),
        .o_new_base    (o_new_base),
        .o_status      (o_status),
        .o_entries     (o_entries)
    );

    // A pending result always keeps the input side closed.
    a_valid_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("result pending while requests are accepted");

    // A dropped add only happens with the queue full.
    a_full_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == dltq_pkg::ST_FULL) |-> (o_entries == 5'(QUEUE_DEPTH)))
        else $error("add dropped with free space left");

    // An expiry never comes with an error status.
    a_expiry_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_expired) |-> (o_status == dltq_pkg::ST_OK))
        else $error("expiry reported with an error status");

endmodule

// ===== tb/tb_delta_list_timer_queue_checker.sv =====
// ----------------------------------------------------------------------------
// Timer queue checker
// Watches both channels, predicts each response from its own delta-list model
// and compares every field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_delta_list_timer_queue_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_req_valid,
    input  logic        i_req_stall,
    input  logic [1:0]  i_op,
    input  logic [15:0] i_seq_id,
    input  logic [15:0] i_delay_ticks,
    input  logic [15:0] i_window_base,
    input  logic        i_rsp_valid,
    input  logic        i_rsp_stall,
    input  logic        i_expired,
    input  logic [15:0] i_expired_seq,
    input  logic [15:0] i_new_base,
    input  logic [1:0]  i_status,
    input  logic [4:0]  i_entries,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_expiries
);

    typedef struct packed {
        logic        expired;
        logic [15:0] expired_seq;
        logic [15:0] new_base;
        logic [1:0]  status;
        logic [4:0]  entries;
    } t_timer_rsp;

    logic [15:0]     timer_seq [dltq_pkg::QUEUE_DEPTH];
    int              timer_delta [dltq_pkg::QUEUE_DEPTH];
    int              timer_count;
    t_timer_rsp      rsp_queue [$];

    function automatic int clamp18(input int v);
        if (v > 131071) return 131071;
        if (v < -131072) return -131072;
        return v;
    endfunction

    function automatic void drop_timer(input int pos);
        if (pos + 1 < timer_count)
            timer_delta[pos+1] = clamp18(timer_delta[pos+1] + timer_delta[pos]);
        for (int i = pos; i + 1 < timer_count; i++) begin
            timer_seq[i]   = timer_seq[i+1];
            timer_delta[i] = timer_delta[i+1];
        end
        timer_count--;
    endfunction

    function automatic void place_timer(input int pos, input logic [15:0] s, input int d);
        for (int i = timer_count; i > pos; i--) begin
            timer_seq[i]   = timer_seq[i-1];
            timer_delta[i] = timer_delta[i-1];
        end
        timer_seq[pos]   = s;
        timer_delta[pos] = d;
        timer_count++;
    endfunction

    function automatic t_timer_rsp apply_request(input logic [1:0] op, input logic [15:0] s,
                                                 input logic [15:0] dly, input logic [15:0] b);
        t_timer_rsp r;
        int         t;
        int         pos;
        logic [15:0] nb;
        r  = '0;
        t  = int'(dly);
        nb = b;
        case (op)
            dltq_pkg::OP_ADD: begin
                if (timer_count >= dltq_pkg::QUEUE_DEPTH) begin
                    r.status = dltq_pkg::ST_FULL;
                end else if (timer_count == 0 || t < timer_delta[0]) begin
                    if (timer_count != 0) timer_delta[0] = clamp18(timer_delta[0] - t);
                    place_timer(0, s, t);
                end else begin
                    pos = 0;
                    while (pos + 1 < timer_count && t >= timer_delta[pos+1]) begin
                        t -= timer_delta[pos+1];
                        pos++;
                    end
                    if (pos + 1 < timer_count)
                        timer_delta[pos+1] = clamp18(timer_delta[pos+1] - t);
                    place_timer(pos + 1, s, clamp18(t));
                end
            end
            dltq_pkg::OP_DEL: begin
                pos = 0;
                while (pos < timer_count && timer_seq[pos] != s) pos++;
                if (pos < timer_count) drop_timer(pos);
                else r.status = dltq_pkg::ST_NOT_FOUND;
            end
            dltq_pkg::OP_TICK: begin
                if (timer_count != 0) begin
                    timer_delta[0] = clamp18(timer_delta[0] - 1);
                    if (timer_delta[0] <= 0) begin
                        r.expired     = 1'b1;
                        r.expired_seq = timer_seq[0];
                        drop_timer(0);
                    end
                end
            end
            default: begin
                while (timer_count != 0 && timer_seq[0] == nb) begin
                    drop_timer(0);
                    nb = nb + 16'd1;
                end
                r.new_base = nb;
            end
        endcase
        r.entries = 5'(timer_count);
        return r;
    endfunction

    assign o_pending = rsp_queue.size();

    always @(posedge i_clk) begin
        t_timer_rsp want;
        t_timer_rsp got;
        if (!i_rst_n) begin
            timer_count   = 0;
            o_fail_count <= 0;
            o_expiries   <= 0;
            rsp_queue.delete();
        end else begin
            if (i_rsp_valid && !i_rsp_stall) begin
                got = {i_expired, i_expired_seq, i_new_base, i_status, i_entries};
                if (rsp_queue.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("ERROR: response with nothing expected: %p", got);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = rsp_queue.pop_front();
                    if (got.expired) o_expiries <= o_expiries + 1;
                    if (got !== want) begin
                        if (o_fail_count < 10)
                            $display("ERROR: mismatch at %0t: expected %p, got %p",
                                     $realtime, want, got);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (i_req_valid && !i_req_stall)
                rsp_queue.push_back(apply_request(i_op, i_seq_id, i_delay_ticks,
                                                  i_window_base));
        end
    end
endmodule

// ===== tb/tb_delta_list_timer_queue.sv =====
// ----------------------------------------------------------------------------
// Timer queue testbench
// Drives directed and random timer requests with random idling on both
// channels; the checker predicts and compares, this top gives the verdict.
// ----------------------------------------------------------------------------
module tb_delta_list_timer_queue;

    logic        i_clk;
    logic        i_rst_n;
    logic        req_valid;
    logic        req_stall;
    logic [1:0]  req_op;
    logic [15:0] req_seq;
    logic [15:0] req_delay;
    logic [15:0] req_base;
    logic        rsp_valid;
    logic        rsp_stall;
    logic        rsp_expired;
    logic [15:0] rsp_expired_seq;
    logic [15:0] rsp_new_base;
    logic [1:0]  rsp_status;
    logic [4:0]  rsp_entries;
    int          fail_count;
    int          pending;
    int          expiries;
    int          cycle_count;

    // Idle percentages for the sender and the receiver, changed per phase.
    int          send_idle_pct;
    int          recv_idle_pct;
    // A small pool of sequence numbers makes deletes and advances hit often.
    logic [15:0] seq_pool_base;
    int          request_total;

    localparam int CYCLE_LIMIT = 1000000;

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    delta_list_timer_queue u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (req_valid),
        .o_stall       (req_stall),
        .i_op          (req_op),
        .i_seq_id      (req_seq),
        .i_delay_ticks (req_delay),
        .i_window_base (req_base),
        .o_valid       (rsp_valid),
        .i_stall       (rsp_stall),
        .o_expired     (rsp_expired),
        .o_expired_seq (rsp_expired_seq),
        .o_new_base    (rsp_new_base),
        .o_status      (rsp_status),
        .o_entries     (rsp_entries)
    );

    tb_delta_list_timer_queue_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req_valid   (req_valid),
        .i_req_stall   (req_stall),
        .i_op          (req_op),
        .i_seq_id      (req_seq),
        .i_delay_ticks (req_delay),
        .i_window_base (req_base),
        .i_rsp_valid   (rsp_valid),
        .i_rsp_stall   (rsp_stall),
        .i_expired     (rsp_expired),
        .i_expired_seq (rsp_expired_seq),
        .i_new_base    (rsp_new_base),
        .i_status      (rsp_status),
        .i_entries     (rsp_entries),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_expiries    (expiries)
    );

    // The receiver stalls at random; each edge draws afresh, so a stall may
    // fall on any phase of the block's work.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_stall <= 1'b0;
        end else begin
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // The watchdog ends the run if the whole run passes the cycle limit, as it
    // would if the block hung.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d responses pending.",
                     cycle_count, pending);
            $display("FAIL delta_list_timer_queue");
            $finish;
        end
    end

    // Present one request and hold it until the block accepts it. The valid
    // stays high from one request to the next unless the sender idles.
    task automatic send_request(input logic [1:0] op, input logic [15:0] s,
                                input logic [15:0] dly, input logic [15:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            req_valid <= 1'b0;
            @(posedge i_clk);
        end
        req_valid <= 1'b1;
        req_op    <= op;
        req_seq   <= s;
        req_delay <= dly;
        req_base  <= b;
        @(posedge i_clk);
        while (req_stall) @(posedge i_clk);
        request_total++;
    endtask

    task automatic release_channel();
        req_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Random request, mostly well formed: adds and deletes over a small pool
    // of sequence numbers, ticks to drain, and advances that usually match.
    // Occasionally any value at all is used, so every bit toggles.
    task automatic send_random_request();
        int          pick;
        logic [1:0]  op;
        logic [15:0] s;
        logic [15:0] dly;
        logic [15:0] b;
        pick = $urandom_range(99);
        s    = seq_pool_base + 16'($urandom_range(23));
        if ($urandom_range(9) == 0) s = 16'($urandom);
        case ($urandom_range(3))
            0: dly = 16'($urandom_range(6));
            1: dly = 16'($urandom_range(40));
            2: dly = 16'($urandom_range(400));
            default: dly = 16'($urandom);
        endcase
        b = seq_pool_base + 16'($urandom_range(3));
        if ($urandom_range(7) == 0) b = 16'($urandom);
        if (pick < 35) op = dltq_pkg::OP_ADD;
        else if (pick < 50) op = dltq_pkg::OP_DEL;
        else if (pick < 85) op = dltq_pkg::OP_TICK;
        else op = dltq_pkg::OP_ADV;
        if (op == dltq_pkg::OP_ADV && $urandom_range(3) == 0)
            seq_pool_base = seq_pool_base + 16'd1;
        send_request(op, s, dly, b);
    endtask

    initial begin
        i_rst_n       = 1'b0;
        req_valid     = 1'b0;
        req_op        = dltq_pkg::OP_TICK;
        req_seq       = '0;
        req_delay     = '0;
        req_base      = '0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        request_total = 0;
        seq_pool_base = 16'hFFF0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: empty-queue corners first, then filling the queue to full.
        send_request(dltq_pkg::OP_TICK, 16'h0000, 16'h0001, 16'h0000);
        send_request(dltq_pkg::OP_ADV, 16'h0000, 16'h0001, 16'hFFFF);
        send_request(dltq_pkg::OP_DEL, 16'hFFFF, 16'h0001, 16'h0000);
        // Zero delay, the largest delay and an equal delay to the head.
        send_request(dltq_pkg::OP_ADD, 16'hFFFF, 16'h0000, 16'h0000);
        send_request(dltq_pkg::OP_ADD, 16'h0000, 16'hFFFF, 16'h0000);
        send_request(dltq_pkg::OP_ADD, 16'h5555, 16'h0000, 16'h0000);
        send_request(dltq_pkg::OP_ADD, 16'hAAAA, 16'h8000, 16'h0000);
        for (int i = 0; i < 11; i++)
            send_request(dltq_pkg::OP_ADD, 16'(i), 16'(3 * i + 1), 16'h0000);
        // This add takes the last free entry and fills the queue.
        send_request(dltq_pkg::OP_ADD, 16'h1234, 16'h0002, 16'h0000);
        send_request(dltq_pkg::OP_DEL, 16'h5555, 16'h0000, 16'h0000);
        send_request(dltq_pkg::OP_DEL, 16'h7777, 16'h0000, 16'h0000);
        // Ticks expire the zero-delay head and walk on through the list.
        for (int i = 0; i < 4; i++)
            send_request(dltq_pkg::OP_TICK, 16'h0000, 16'h0000, 16'h0000);
        // Window advance across the wrap from 65535 to 0.
        send_request(dltq_pkg::OP_ADV, 16'h0000, 16'h0000, 16'hFFFF);
        send_request(dltq_pkg::OP_ADV, 16'h0000, 16'h0000, 16'h0000);

        // Random part in three idling phases.
        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 38 : (phase == 1) ? 48 : 0;
            recv_idle_pct = (phase == 0) ? 48 : (phase == 1) ? 38 : 0;
            for (int n = 0; n < 430; n++) send_random_request();
        end
        release_channel();

        while (pending != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);

        $display("Sent %0d requests (adds, deletes, ticks, advances) over three idling phases;",
                 request_total);
        $display("%0d timers expired, %0d mismatches seen.", expiries, fail_count);
        if (fail_count == 0) begin
            $display("PASS delta_list_timer_queue");
        end else begin
            $display("FAIL delta_list_timer_queue");
        end
        $finish;
    end
endmodule

// ===== delta_list_timer_queue.f =====
rtl/dltq_pkg.sv
rtl/dltq_ctrl.sv
rtl/dltq_dp.sv
rtl/delta_list_timer_queue.sv
tb/tb_delta_list_timer_queue_checker.sv
tb/tb_delta_list_timer_queue.sv
